>>> sv/podo_pkg.sv
// Shared types, constants and the quarter-wave sine generator for the odometry integrator.
package podo_pkg;

	typedef enum logic [1:0] {
		FUNC_CMD   = 2'd0,
		FUNC_TICK  = 2'd1,
		FUNC_RESET = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CALC,
		S_OUT
	} state_t;

	localparam int unsigned POS_W   = 48;
	localparam int unsigned HEAD_W  = 32;
	localparam int unsigned VEL_W   = 16;
	localparam int unsigned YAW_W   = 24;
	localparam int unsigned AGE_W   = 24;
	localparam int unsigned DT_W    = 16;
	localparam int unsigned TRIG_W  = 15;

	localparam logic [AGE_W-1:0] AGE_MAX       = '1;
	localparam logic [AGE_W-1:0] TIMEOUT_RESET = 24'd524288;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned TAYLOR_DIV [1:10] =
		'{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342, 64'd420};

	// Q15 sine of k*(pi/2)/2^bits by integer Taylor series, evaluated at elaboration
	function automatic logic [TRIG_W-1:0] quarter_sine(input int unsigned k,
		input int unsigned bits);
		longint unsigned a;
		longint unsigned a2;
		longint unsigned term;
		longint          sum;
		longint          r;
		a    = (HALF_PI_Q30 * longint'(k)) >> bits;
		a2   = (a * a) >> 30;
		term = a;
		sum  = longint'(a);
		for (int n = 1; n <= 10; n++) begin
			term = ((term * a2) >> 30) / TAYLOR_DIV[n];
			if (n % 2 == 1) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		if (sum > (longint'(1) << 30)) begin
			sum = longint'(1) << 30;
		end
		r = (sum * 32767 + (longint'(1) << 29)) >>> 30;
		if (r > 32767) begin
			r = 32767;
		end
		return r[TRIG_W-1:0];
	endfunction

endpackage

>>> sv/podo_if.sv
// Valid/ready channel interfaces for command beats and pose beats.
interface podo_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic signed [15:0] cmd_vel_x;
	logic signed [15:0] cmd_vel_y;
	logic signed [23:0] cmd_yaw_rate;
	logic [15:0] tick_time;

	modport source (output valid, func, cmd_vel_x, cmd_vel_y, cmd_yaw_rate, tick_time,
		input ready);
	modport sink (input valid, func, cmd_vel_x, cmd_vel_y, cmd_yaw_rate, tick_time,
		output ready);
endinterface

interface podo_pose_if;
	logic        valid;
	logic        ready;
	logic signed [47:0] pose_x;
	logic signed [47:0] pose_y;
	logic [31:0] pose_heading;
	logic signed [15:0] now_vel_x;
	logic signed [15:0] now_vel_y;
	logic signed [23:0] now_yaw_rate;
	logic        stale_flag;

	modport source (output valid, pose_x, pose_y, pose_heading, now_vel_x, now_vel_y,
		now_yaw_rate, stale_flag, input ready);
	modport sink (input valid, pose_x, pose_y, pose_heading, now_vel_x, now_vel_y,
		now_yaw_rate, stale_flag, output ready);
endinterface

>>> sv/planar_odometry_integrator_unit.sv
// Dead-reckoning pose integrator: sequencer, shared multiplier and trig table.
//
// Usage: beats arrive on cmd (valid/ready). func selects a velocity command, a
// time tick, a pose reset, or (code 3) a no-op. Every cmd beat yields exactly one
// pose beat carrying x, y, heading, the current velocities and the stale flag.
// cfg_wr_en/cfg_wr_data load the 24-bit command timeout; write it only while idle.
//
// Timing: command, pose reset and no-op beats raise pose.valid in the cycle after
// accept. A tick runs the sequencer and then raises pose.valid: two reads of the
// quarter-wave sine table (one registered read port), one step to fold the quadrant,
// then eight steps of the one 33x17 signed multiplier (four rotation products, three
// products by dt, one heading update). cmd.ready is high only while idle, so one beat
// is in flight at a time; a new beat is taken only after the pose beat is taken.
//
// Reset: arst_n clears pose, velocities and command age, and loads the default
// timeout. When the pose receiver stalls, the result is held and cmd.ready
// stays low until the pose beat is taken.
module planar_odometry_integrator_unit #(
	parameter int unsigned TRIG_INDEX_BITS = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	podo_cmd_if.sink                    cmd,
	podo_pose_if.source                 pose,
	input  logic                        cfg_wr_en,
	input  logic [podo_pkg::AGE_W-1:0]  cfg_wr_data
);

	localparam int unsigned TIB  = TRIG_INDEX_BITS;
	localparam int unsigned QSZ  = 1 << TIB;
	localparam logic [TIB:0] Q_ADDR = (TIB+1)'(QSZ);

	localparam logic [3:0] ST_READ_A = 4'd0;
	localparam logic [3:0] ST_READ_B = 4'd1;
	localparam logic [3:0] ST_QUAD   = 4'd2;
	localparam logic [3:0] ST_VXC    = 4'd3;
	localparam logic [3:0] ST_VYS    = 4'd4;
	localparam logic [3:0] ST_VXS    = 4'd5;
	localparam logic [3:0] ST_VYC    = 4'd6;
	localparam logic [3:0] ST_SXDT   = 4'd7;
	localparam logic [3:0] ST_SYDT   = 4'd8;
	localparam logic [3:0] ST_VTDT   = 4'd9;
	localparam logic [3:0] ST_HEAD   = 4'd10;

	localparam int unsigned SUM_W  = 33;
	localparam int unsigned MB_W   = 17;
	localparam int unsigned PROD_W = SUM_W + MB_W;
	localparam int unsigned STEP_W = PROD_W - 21;

	podo_pkg::state_t state_q, state_d;
	logic [3:0] step_q;

	logic [podo_pkg::AGE_W-1:0]  timeout_q;
	logic [podo_pkg::AGE_W-1:0]  age_q;
	logic signed [podo_pkg::POS_W-1:0] pos_x_q, pos_y_q;
	logic [podo_pkg::HEAD_W-1:0] heading_q;
	logic signed [podo_pkg::VEL_W-1:0] vel_x_q, vel_y_q;
	logic signed [podo_pkg::YAW_W-1:0] vel_turn_q;
	logic stale_q;
	logic [podo_pkg::DT_W-1:0] dt_q;

	logic [podo_pkg::TRIG_W-1:0] trig_tab [QSZ+1];
	logic [TIB:0]                rom_addr;
	logic [podo_pkg::TRIG_W-1:0] rom_q, a_q;
	logic signed [15:0]          sin_q, cos_q;
	logic signed [15:0]          a_s, b_s;
	logic [TIB-1:0]              idx;

	logic signed [SUM_W-1:0]  mul_a, t_q, sx_q, sy_q;
	logic signed [MB_W-1:0]   mul_b, dt_s;
	logic signed [PROD_W-1:0] prod, prod_q;
	logic signed [STEP_W-1:0] pos_step;
	logic [podo_pkg::HEAD_W-1:0] head_step;
	logic [podo_pkg::AGE_W:0] age_sum;
	logic [podo_pkg::AGE_W-1:0] age_new;
	logic accept;

	for (genvar k = 0; k <= QSZ; k++) begin : g_trig
		assign trig_tab[k] = podo_pkg::quarter_sine(k, TIB);
	end

	function automatic logic signed [podo_pkg::POS_W-1:0] sat_add(
		input logic signed [podo_pkg::POS_W-1:0] p,
		input logic signed [STEP_W-1:0] d);
		logic signed [podo_pkg::POS_W:0] s;
		s = (podo_pkg::POS_W+1)'(p) + (podo_pkg::POS_W+1)'(d);
		if (s[podo_pkg::POS_W] != s[podo_pkg::POS_W-1]) begin
			return s[podo_pkg::POS_W] ? {1'b1, {(podo_pkg::POS_W-1){1'b0}}}
				: {1'b0, {(podo_pkg::POS_W-1){1'b1}}};
		end
		return s[podo_pkg::POS_W-1:0];
	endfunction

	assign accept  = cmd.valid && cmd.ready;
	assign idx     = heading_q[29 -: TIB];
	assign age_sum = {1'b0, age_q} + (podo_pkg::AGE_W+1)'(cmd.tick_time);
	assign age_new = age_sum[podo_pkg::AGE_W] ? podo_pkg::AGE_MAX : age_sum[podo_pkg::AGE_W-1:0];
	assign rom_addr = (step_q == ST_READ_A) ? {1'b0, idx} : Q_ADDR - {1'b0, idx};
	assign a_s  = $signed({1'b0, a_q});
	assign b_s  = $signed({1'b0, rom_q});
	assign dt_s = $signed({1'b0, dt_q});

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (step_q)
			ST_VXC: begin
				mul_a = SUM_W'(vel_x_q);
				mul_b = MB_W'(cos_q);
			end
			ST_VYS: begin
				mul_a = SUM_W'(vel_y_q);
				mul_b = MB_W'(sin_q);
			end
			ST_VXS: begin
				mul_a = SUM_W'(vel_x_q);
				mul_b = MB_W'(sin_q);
			end
			ST_VYC: begin
				mul_a = SUM_W'(vel_y_q);
				mul_b = MB_W'(cos_q);
			end
			ST_SXDT: begin
				mul_a = sx_q;
				mul_b = dt_s;
			end
			ST_SYDT: begin
				mul_a = sy_q;
				mul_b = dt_s;
			end
			ST_VTDT: begin
				mul_a = SUM_W'(vel_turn_q);
				mul_b = dt_s;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod      = mul_a * mul_b;
	assign pos_step  = STEP_W'((prod_q + PROD_W'(64'sd1048576)) >>> 21);
	assign head_step = podo_pkg::HEAD_W'((prod_q + PROD_W'(64'sd8)) >>> 4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= podo_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd.ready  = 1'b0;
		pose.valid = 1'b0;
		case (state_q)
			podo_pkg::S_IDLE: begin
				cmd.ready = 1'b1;
				if (cmd.valid) begin
					state_d = (cmd.func == podo_pkg::FUNC_TICK) ? podo_pkg::S_CALC
						: podo_pkg::S_OUT;
				end
			end
			podo_pkg::S_CALC: begin
				if (step_q == ST_HEAD) begin
					state_d = podo_pkg::S_OUT;
				end
			end
			podo_pkg::S_OUT: begin
				pose.valid = 1'b1;
				if (pose.ready) begin
					state_d = podo_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = podo_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q  <= podo_pkg::TIMEOUT_RESET;
			age_q      <= '0;
			pos_x_q    <= '0;
			pos_y_q    <= '0;
			heading_q  <= '0;
			vel_x_q    <= '0;
			vel_y_q    <= '0;
			vel_turn_q <= '0;
			stale_q    <= 1'b0;
			step_q     <= ST_READ_A;
		end else begin
			if (cfg_wr_en) begin
				timeout_q <= cfg_wr_data;
			end
			if (state_q == podo_pkg::S_CALC) begin
				step_q <= (step_q == ST_HEAD) ? ST_READ_A : step_q + 4'd1;
				case (step_q)
					ST_SYDT: pos_x_q   <= sat_add(pos_x_q, pos_step);
					ST_VTDT: pos_y_q   <= sat_add(pos_y_q, pos_step);
					ST_HEAD: heading_q <= heading_q + head_step;
					default: begin
					end
				endcase
			end
			if (accept) begin
				stale_q <= 1'b0;
				case (cmd.func)
					podo_pkg::FUNC_CMD: begin
						vel_x_q    <= cmd.cmd_vel_x;
						vel_y_q    <= cmd.cmd_vel_y;
						vel_turn_q <= cmd.cmd_yaw_rate;
						age_q      <= '0;
					end
					podo_pkg::FUNC_TICK: begin
						age_q <= age_new;
						if (age_new > timeout_q) begin
							vel_x_q    <= '0;
							vel_y_q    <= '0;
							vel_turn_q <= '0;
							stale_q    <= 1'b1;
						end
					end
					podo_pkg::FUNC_RESET: begin
						pos_x_q   <= '0;
						pos_y_q   <= '0;
						heading_q <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		rom_q  <= trig_tab[rom_addr];
		prod_q <= prod;
		if (accept) begin
			dt_q <= cmd.tick_time;
		end
		case (step_q)
			ST_READ_B: a_q <= rom_q;
			ST_QUAD: begin
				case (heading_q[31:30])
					2'd0: begin
						sin_q <= a_s;
						cos_q <= b_s;
					end
					2'd1: begin
						sin_q <= b_s;
						cos_q <= -a_s;
					end
					2'd2: begin
						sin_q <= -a_s;
						cos_q <= -b_s;
					end
					default: begin
						sin_q <= -b_s;
						cos_q <= a_s;
					end
				endcase
			end
			ST_VYS:  t_q  <= prod_q[SUM_W-1:0];
			ST_VXS:  sx_q <= t_q - prod_q[SUM_W-1:0];
			ST_VYC:  t_q  <= prod_q[SUM_W-1:0];
			ST_SXDT: sy_q <= t_q + prod_q[SUM_W-1:0];
			default: begin
			end
		endcase
	end

	assign pose.pose_x       = pos_x_q;
	assign pose.pose_y       = pos_y_q;
	assign pose.pose_heading = heading_q;
	assign pose.now_vel_x    = vel_x_q;
	assign pose.now_vel_y    = vel_y_q;
	assign pose.now_yaw_rate = vel_turn_q;
	assign pose.stale_flag   = stale_q;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.ready && pose.valid))
		else $error("cmd.ready and pose.valid high together");

	a_stale_zero: assert property (@(posedge clk) disable iff (!arst_n)
		pose.valid && stale_q |-> vel_x_q == '0 && vel_y_q == '0 && vel_turn_q == '0
			&& age_q > timeout_q)
		else $error("stale result with live velocity");

	a_tick_calc: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd.func == podo_pkg::FUNC_TICK |=> state_q == podo_pkg::S_CALC
			&& step_q == ST_READ_A)
		else $error("tick beat did not start the sequencer");

	a_step_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != podo_pkg::S_CALC |-> step_q == ST_READ_A)
		else $error("step counter running outside calc");

	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		pose.valid && !pose.ready |=> $stable(pos_x_q) && $stable(pos_y_q)
			&& $stable(heading_q) && $stable(stale_q))
		else $error("pose changed while stalled");

endmodule

>>> tb/podo_pose_checker.sv
// Pose checker: tracks the odometry state from command beats and checks every pose beat.
module podo_pose_checker #(
	parameter int unsigned TRIG_INDEX_BITS = 10
) (
	input  logic                       clk,
	input  logic                       arst_n,
	podo_cmd_if                        cmd,
	podo_pose_if                       pose,
	input  logic                       cfg_wr_en,
	input  logic [podo_pkg::AGE_W-1:0] cfg_wr_data,
	output int                         mismatches,
	output int                         pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned QUARTER = 1 << TRIG_INDEX_BITS;
	localparam longint POS_HI = (64'sd1 <<< 47) - 64'sd1;
	localparam longint POS_LO = -(64'sd1 <<< 47);

	typedef struct {
		logic signed [47:0] x;
		logic signed [47:0] y;
		logic [31:0]        heading;
		logic signed [15:0] vx;
		logic signed [15:0] vy;
		logic signed [23:0] yaw;
		logic               stale;
	} pose_t;

	int sine_lut [0:QUARTER];

	logic signed [47:0] pos_x;
	logic signed [47:0] pos_y;
	logic [31:0]        hdg;
	logic signed [15:0] vel_x;
	logic signed [15:0] vel_y;
	logic signed [23:0] yaw_rate;
	logic [podo_pkg::AGE_W-1:0] age;
	logic [podo_pkg::AGE_W-1:0] timeout;

	pose_t expected_poses [$];
	int    fail_count = 0;
	int    queued = 0;

	assign mismatches = fail_count;
	assign pending    = queued;

	function automatic int sine_q15(int unsigned k);
		longint unsigned ang;
		longint unsigned ang_sq;
		longint unsigned term;
		longint          acc;
		longint          scaled;
		ang    = (podo_pkg::HALF_PI_Q30 * k) >> TRIG_INDEX_BITS;
		ang_sq = (ang * ang) >> 30;
		term   = ang;
		acc    = longint'(ang);
		for (int n = 1; n <= 10; n++) begin
			term = ((term * ang_sq) >> 30) / 64'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		if (acc < 0) begin
			acc = 0;
		end
		if (acc > (64'sd1 <<< 30)) begin
			acc = 64'sd1 <<< 30;
		end
		scaled = (acc * 32767 + (64'sd1 <<< 29)) >>> 30;
		if (scaled > 32767) begin
			scaled = 32767;
		end
		return int'(scaled);
	endfunction

	function automatic logic signed [47:0] clamp_pos(longint v);
		if (v > POS_HI) begin
			return 48'(POS_HI);
		end
		if (v < POS_LO) begin
			return 48'(POS_LO);
		end
		return 48'(v);
	endfunction

	function automatic pose_t step_pose(logic [1:0] fn, logic signed [15:0] cvx,
		logic signed [15:0] cvy, logic signed [23:0] cyaw, logic [15:0] dt);
		pose_t       p;
		logic [24:0] age_sum;
		int unsigned idx;
		int          a;
		int          b;
		int          s;
		int          c;
		longint      dx;
		longint      dy;
		longint      dh;
		p.stale = 1'b0;
		case (fn)
			podo_pkg::FUNC_CMD: begin
				vel_x    = cvx;
				vel_y    = cvy;
				yaw_rate = cyaw;
				age      = '0;
			end
			podo_pkg::FUNC_TICK: begin
				age_sum = {1'b0, age} + 25'(dt);
				age     = age_sum[24] ? podo_pkg::AGE_MAX : age_sum[23:0];
				if (age > timeout) begin
					vel_x    = '0;
					vel_y    = '0;
					yaw_rate = '0;
					p.stale  = 1'b1;
				end
				idx = 32'(hdg[29 -: TRIG_INDEX_BITS]);
				a   = sine_lut[idx];
				b   = sine_lut[QUARTER - idx];
				case (hdg[31:30])
					2'd0: begin
						s = a;
						c = b;
					end
					2'd1: begin
						s = b;
						c = -a;
					end
					2'd2: begin
						s = -a;
						c = -b;
					end
					default: begin
						s = -b;
						c = a;
					end
				endcase
				dx = (longint'(vel_x) * c - longint'(vel_y) * s) * longint'(dt);
				dy = (longint'(vel_x) * s + longint'(vel_y) * c) * longint'(dt);
				dh = longint'(yaw_rate) * longint'(dt);
				pos_x = clamp_pos(longint'(pos_x) + ((dx + 64'sd1048576) >>> 21));
				pos_y = clamp_pos(longint'(pos_y) + ((dy + 64'sd1048576) >>> 21));
				hdg   = hdg + 32'((dh + 64'sd8) >>> 4);
			end
			podo_pkg::FUNC_RESET: begin
				pos_x = '0;
				pos_y = '0;
				hdg   = '0;
			end
			default: begin
			end
		endcase
		p.x       = pos_x;
		p.y       = pos_y;
		p.heading = hdg;
		p.vx      = vel_x;
		p.vy      = vel_y;
		p.yaw     = yaw_rate;
		return p;
	endfunction

	task automatic report(string what, logic [63:0] want, logic [63:0] got);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%0t: pose beat mismatch on %s: expected %h, got %h",
				$time, what, want, got);
		end
	endtask

	initial begin
		for (int k = 0; k <= QUARTER; k++) begin
			sine_lut[k] = sine_q15(k);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		pose_t want;
		if (!arst_n) begin
			pos_x    = '0;
			pos_y    = '0;
			hdg      = '0;
			vel_x    = '0;
			vel_y    = '0;
			yaw_rate = '0;
			age      = '0;
			timeout  = podo_pkg::TIMEOUT_RESET;
			expected_poses.delete();
			queued = 0;
		end else begin
			if (pose.valid && pose.ready) begin
				if (expected_poses.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("%0t: pose beat with nothing outstanding", $time);
					end
				end else begin
					want = expected_poses.pop_front();
					if (pose.pose_x !== want.x)
						report("pose_x", 64'(want.x), 64'(pose.pose_x));
					if (pose.pose_y !== want.y)
						report("pose_y", 64'(want.y), 64'(pose.pose_y));
					if (pose.pose_heading !== want.heading)
						report("pose_heading", 64'(want.heading), 64'(pose.pose_heading));
					if (pose.now_vel_x !== want.vx)
						report("now_vel_x", 64'(want.vx), 64'(pose.now_vel_x));
					if (pose.now_vel_y !== want.vy)
						report("now_vel_y", 64'(want.vy), 64'(pose.now_vel_y));
					if (pose.now_yaw_rate !== want.yaw)
						report("now_yaw_rate", 64'(want.yaw), 64'(pose.now_yaw_rate));
					if (pose.stale_flag !== want.stale)
						report("stale_flag", 64'(want.stale), 64'(pose.stale_flag));
				end
			end
			if (cfg_wr_en) begin
				timeout = cfg_wr_data;
			end
			if (cmd.valid && cmd.ready) begin
				expected_poses.push_back(step_pose(cmd.func, cmd.cmd_vel_x, cmd.cmd_vel_y,
					cmd.cmd_yaw_rate, cmd.tick_time));
			end
			queued = expected_poses.size();
		end
	end

endmodule

>>> tb/planar_odometry_integrator_unit_tb.sv
// Testbench top: clock, reset, command and pose traffic, timeout updates and the verdict.
module planar_odometry_integrator_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_wr_en;
	logic [podo_pkg::AGE_W-1:0] cfg_wr_data;
	bit                         jitter;
	bit                         rx_stall_req;
	bit                         rx_stall_done;
	int                         mismatches;
	int                         pending;

	podo_cmd_if  cmd_ch ();
	podo_pose_if pose_ch ();

	planar_odometry_integrator_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd_ch),
		.pose        (pose_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	podo_pose_checker u_pose_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd_ch),
		.pose        (pose_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.mismatches  (mismatches),
		.pending     (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		forever begin
			if (rx_stall_req && !rx_stall_done) begin
				pose_ch.ready <= 1'b0;
				repeat (200) @(posedge clk);
				rx_stall_done = 1'b1;
			end else if (jitter && $urandom_range(0, 4) == 0) begin
				pose_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end else begin
				pose_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	task automatic send_beat(podo_pkg::func_t fn, logic [15:0] vx, logic [15:0] vy,
		logic [23:0] yaw, logic [15:0] dt);
		if (jitter && $urandom_range(0, 3) == 0) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		cmd_ch.valid        <= 1'b1;
		cmd_ch.func         <= fn;
		cmd_ch.cmd_vel_x    <= vx;
		cmd_ch.cmd_vel_y    <= vy;
		cmd_ch.cmd_yaw_rate <= yaw;
		cmd_ch.tick_time    <= dt;
		do @(posedge clk); while (!cmd_ch.ready);
	endtask

	task automatic tick(logic [15:0] dt);
		send_beat(podo_pkg::FUNC_TICK, 16'($urandom), 16'($urandom), 24'($urandom), dt);
	endtask

	// drain, then load the timeout while idle
	task automatic set_timeout(logic [podo_pkg::AGE_W-1:0] limit);
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= limit;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	task automatic run_mix(int beats);
		int unsigned     pick;
		podo_pkg::func_t fn;
		logic [15:0]     dt;
		logic [23:0]     yaw;
		for (int i = 0; i < beats; i++) begin
			pick = $urandom_range(0, 99);
			fn = (pick < 18) ? podo_pkg::FUNC_CMD : (pick < 88) ? podo_pkg::FUNC_TICK :
				(pick < 94) ? podo_pkg::FUNC_RESET : podo_pkg::FUNC_NONE;
			case ($urandom_range(0, 2))
				0: dt = 16'($urandom);
				1: dt = 16'($urandom_range(0, 255));
				default: dt = 16'($urandom_range(60000, 65535));
			endcase
			yaw = $urandom_range(0, 1) ? 24'($urandom) : 24'($urandom_range(0, 4000) - 2000);
			send_beat(fn, 16'($urandom), 16'($urandom), yaw, dt);
		end
	endtask

	initial begin
		jitter              = 1'b1;
		rx_stall_req        = 1'b0;
		arst_n              <= 1'b0;
		cfg_wr_en           <= 1'b0;
		cfg_wr_data         <= '0;
		cmd_ch.valid        <= 1'b0;
		cmd_ch.func         <= podo_pkg::FUNC_NONE;
		cmd_ch.cmd_vel_x    <= '0;
		cmd_ch.cmd_vel_y    <= '0;
		cmd_ch.cmd_yaw_rate <= '0;
		cmd_ch.tick_time    <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tick(16'd0);
		tick(16'hFFFF);
		send_beat(podo_pkg::FUNC_CMD, 16'sh7FFF, 16'sh8000, 24'sh7FFFFF, 16'd0);
		tick(16'hFFFF);
		tick(16'd0);
		tick(16'd1);
		send_beat(podo_pkg::FUNC_NONE, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 16'hFFFF);
		send_beat(podo_pkg::FUNC_CMD, 16'sh8000, 16'sh7FFF, 24'sh800000, 16'hFFFF);
		tick(16'hFFFF);
		tick(16'hFFFF);
		send_beat(podo_pkg::FUNC_RESET, 16'h1234, 16'h4321, 24'h0F0F0F, 16'h5555);
		// age lands exactly on the default timeout, then one past it
		send_beat(podo_pkg::FUNC_CMD, 16'sd1000, -16'sd500, 24'sd300000, 16'd0);
		repeat (8) tick(16'hFFFF);
		tick(16'd8);
		tick(16'd1);
		tick(16'd100);

		set_timeout('0);
		send_beat(podo_pkg::FUNC_CMD, 16'sd2000, 16'sd700, -24'sd90000, 16'd0);
		tick(16'd0);
		tick(16'd1);
		run_mix(300);

		// saturate the command age under the largest timeout
		set_timeout(podo_pkg::AGE_MAX);
		send_beat(podo_pkg::FUNC_CMD, 16'sd300, -16'sd300, 24'sd20000, 16'd0);
		repeat (260) tick(16'hFFFF);
		set_timeout(podo_pkg::AGE_MAX - 24'd1);
		tick(16'd0);
		run_mix(300);

		set_timeout(24'($urandom));
		rx_stall_req = 1'b1;
		run_mix(400);

		set_timeout(podo_pkg::TIMEOUT_RESET);
		run_mix(400);

		set_timeout(24'($urandom_range(0, 300000)));
		run_mix(300);

		set_timeout(24'($urandom_range(0, 1000000)));
		jitter = 1'b0;
		run_mix(300);

		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

>>> filelist.f
sv/podo_pkg.sv
sv/podo_if.sv
sv/planar_odometry_integrator_unit.sv
tb/podo_pose_checker.sv
tb/planar_odometry_integrator_unit_tb.sv
